[sv/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// Holds parser phase codes, event codes, error codes and the result layout.
// No dependencies.
package wsd_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Result event codes
    localparam logic [1:0] EV_HDR_BYTE = 2'd0;
    localparam logic [1:0] EV_HDR_DONE = 2'd1;
    localparam logic [1:0] EV_PAYLOAD  = 2'd2;
    localparam logic [1:0] EV_ERROR    = 2'd3;

    // Protocol error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_RSV        = 4'd1;
    localparam logic [3:0] ERR_OPCODE     = 4'd2;
    localparam logic [3:0] ERR_LEN_MSB    = 4'd3;
    localparam logic [3:0] ERR_MASK_ROLE  = 4'd4;
    localparam logic [3:0] ERR_CTRL_FRAG  = 4'd5;
    localparam logic [3:0] ERR_CTRL_LONG  = 4'd6;
    localparam logic [3:0] ERR_UNEXP_CONT = 4'd7;
    localparam logic [3:0] ERR_EXP_CONT   = 4'd8;

    // Frame header constants
    localparam logic [6:0]  LEN_EXT16      = 7'd126;
    localparam logic [6:0]  LEN_EXT64      = 7'd127;
    localparam logic [62:0] CTRL_MAX_LEN   = 63'd125;
    localparam logic [3:0]  OPC_CONT       = 4'd0;
    localparam logic [3:0]  OPC_LAST_DATA  = 4'd2;
    localparam logic [3:0]  OPC_FIRST_CTRL = 4'd8;
    localparam logic [3:0]  OPC_LAST_CTRL  = 4'd10;

    // Result tdata layout; first member sits in the highest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [3:0]  error_code;
        logic [62:0] payload_length;
        logic        frame_masked;
        logic        final_fragment;
        logic [3:0]  opcode;
        logic [7:0]  data_byte;
    } result_t;

    // Supported opcodes: 0, 1, 2, 8, 9, 10
    function automatic logic opcode_supported(input logic [3:0] op);
        opcode_supported = (op <= OPC_LAST_DATA)
                           || ((op >= OPC_FIRST_CTRL) && (op <= OPC_LAST_CTRL));
    endfunction

endpackage

[sv/websocket_frame_deframer.sv]
// WebSocket frame deframer top level: input register, parser logic, result register.
// Depends on wsd_pkg for codes and the result layout.
//
// Usage:
//   s_axis carries one received stream byte per item in tdata; tuser is
//   start_over, which clears the parser, fragment tracking and any latched
//   error before the byte is taken as the first header byte.
//   m_axis returns exactly one result item per input item: tuser is the
//   event (header byte, header complete, payload byte, error), tlast marks
//   the last payload byte or the header of an empty frame, and tdata holds
//   the unmasked byte, frame fields, declared length and error code.
//   cfg_wr_en/cfg_wr_data write role_is_server (1 server, 0 client); write
//   it only while no item is in flight.
// Timing:
//   An accepted item is held in the input register, parsed combinationally,
//   and its result is registered in the result register that drives m_axis.
//   One item per cycle is sustained while m_axis does not stall; the
//   byte-to-byte parser state update is the only loop.
// Reset and stall:
//   Reset sets server role and clears all parser state. When m_axis stalls,
//   the result holds, one more item is taken into the input register, and
//   then s_axis_tready drops until the result is taken.
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // role_is_server
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tuser,    // [0] start_over
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,    // [7:0] data_byte, [11:8] opcode,
                                         // [12] final_fragment, [13] frame_masked,
                                         // [76:14] payload_length, [80:77] error_code
    output logic [1:0]  m_axis_tuser,    // [1:0] event_res
    output logic        m_axis_tlast     // frame_end
);

    // Configuration and pipeline registers
    logic        role_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg;
    logic [87:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_last_reg;

    // Parser state
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       fhb_reg, fhb_next;
    logic [3:0]       op_reg, op_next;
    logic             fin_reg, fin_next;
    logic             msk_reg, msk_next;
    logic             len64_reg, len64_next;
    logic [2:0]       lrd_reg, lrd_next;
    logic [62:0]      acc_reg, acc_next;
    logic [3:0][7:0]  key_reg, key_next;
    logic [1:0]       mrd_reg, mrd_next;
    logic [62:0]      rem_reg, rem_next;
    logic [1:0]       kidx_reg, kidx_next;
    logic             frag_reg, frag_next;
    logic [3:0]       err_reg, err_next;

    // State as seen by the item, after an optional start_over clear
    logic [2:0]       phase_cur;
    logic [7:0]       fhb_cur;
    logic [3:0]       op_cur;
    logic             fin_cur;
    logic             msk_cur;
    logic             len64_cur;
    logic [2:0]       lrd_cur;
    logic [62:0]      acc_cur;
    logic [3:0][7:0]  key_cur;
    logic [1:0]       mrd_cur;
    logic [62:0]      rem_cur;
    logic [1:0]       kidx_cur;
    logic             frag_cur;
    logic [3:0]       err_cur;

    logic             advance;
    logic [1:0]       ev;
    logic [7:0]       data;
    logic             ends;
    logic [3:0]       err;
    logic [3:0]       hr_err;
    logic             do_hdr;
    logic             do_end;
    wsd_pkg::result_t res;

    // Move an item from the input register into the result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Apply start_over as a clear ahead of the byte
    always_comb
    begin
        if (in_start_reg)
        begin
            phase_cur = wsd_pkg::PH_HDR0;
            fhb_cur   = '0;
            op_cur    = '0;
            fin_cur   = 1'b0;
            msk_cur   = 1'b0;
            len64_cur = 1'b0;
            lrd_cur   = '0;
            acc_cur   = '0;
            key_cur   = '0;
            mrd_cur   = '0;
            rem_cur   = '0;
            kidx_cur  = '0;
            frag_cur  = 1'b0;
            err_cur   = wsd_pkg::ERR_NONE;
        end
        else
        begin
            phase_cur = phase_reg;
            fhb_cur   = fhb_reg;
            op_cur    = op_reg;
            fin_cur   = fin_reg;
            msk_cur   = msk_reg;
            len64_cur = len64_reg;
            lrd_cur   = lrd_reg;
            acc_cur   = acc_reg;
            key_cur   = key_reg;
            mrd_cur   = mrd_reg;
            rem_cur   = rem_reg;
            kidx_cur  = kidx_reg;
            frag_cur  = frag_reg;
            err_cur   = err_reg;
        end
    end

    // Parse one byte
    always_comb
    begin
        phase_next = phase_cur;
        fhb_next   = fhb_cur;
        op_next    = op_cur;
        fin_next   = fin_cur;
        msk_next   = msk_cur;
        len64_next = len64_cur;
        lrd_next   = lrd_cur;
        acc_next   = acc_cur;
        key_next   = key_cur;
        mrd_next   = mrd_cur;
        rem_next   = rem_cur;
        kidx_next  = kidx_cur;
        frag_next  = frag_cur;
        err_next   = err_cur;
        ev         = wsd_pkg::EV_HDR_BYTE;
        data       = '0;
        ends       = 1'b0;
        err        = wsd_pkg::ERR_NONE;
        hr_err     = wsd_pkg::ERR_NONE;
        do_hdr     = 1'b0;
        do_end     = 1'b0;

        if (err_cur != wsd_pkg::ERR_NONE)
        begin
            // Repeat the latched error, hold all state
            ev = wsd_pkg::EV_ERROR;
        end
        else
        begin
            unique case (phase_cur)
                wsd_pkg::PH_HDR0:
                begin
                    fhb_next   = in_byte_reg;
                    phase_next = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1:
                begin
                    if (fhb_cur[6:4] != 3'd0)
                    begin
                        err = wsd_pkg::ERR_RSV;
                    end
                    else
                    begin
                        fin_next = fhb_cur[7];
                        op_next  = fhb_cur[3:0];
                        msk_next = 1'b0;
                        acc_next = '0;
                        if (!wsd_pkg::opcode_supported(fhb_cur[3:0]))
                        begin
                            err = wsd_pkg::ERR_OPCODE;
                        end
                        else
                        begin
                            msk_next = in_byte_reg[7];
                            lrd_next = '0;
                            mrd_next = '0;
                            if (in_byte_reg[6:0] < wsd_pkg::LEN_EXT16)
                            begin
                                acc_next = {56'd0, in_byte_reg[6:0]};
                                if (in_byte_reg[7])
                                    phase_next = wsd_pkg::PH_MASK;
                                else
                                    do_hdr = 1'b1;
                            end
                            else
                            begin
                                len64_next = (in_byte_reg[6:0] == wsd_pkg::LEN_EXT64);
                                phase_next = wsd_pkg::PH_EXTLEN;
                            end
                        end
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    if (len64_cur && (lrd_cur == 3'd0) && in_byte_reg[7])
                    begin
                        err = wsd_pkg::ERR_LEN_MSB;
                    end
                    else
                    begin
                        acc_next = {acc_cur[54:0], in_byte_reg};
                        lrd_next = lrd_cur + 3'd1;
                        if (lrd_cur == (len64_cur ? 3'd7 : 3'd1))
                        begin
                            if (msk_cur)
                                phase_next = wsd_pkg::PH_MASK;
                            else
                                do_hdr = 1'b1;
                        end
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key_next[mrd_cur] = in_byte_reg;
                    mrd_next          = mrd_cur + 2'd1;
                    if (mrd_cur == 2'd3)
                        do_hdr = 1'b1;
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    ev        = wsd_pkg::EV_PAYLOAD;
                    data      = msk_cur ? (in_byte_reg ^ key_cur[kidx_cur]) : in_byte_reg;
                    kidx_next = kidx_cur + 2'd1;
                    rem_next  = rem_cur - 63'd1;
                    if (rem_cur == 63'd1)
                    begin
                        do_end = 1'b1;
                        ends   = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase

            // Check the completed header; if it passes, open the payload or end an empty frame
            if (do_hdr)
            begin
                priority if (msk_next != role_reg)
                    hr_err = wsd_pkg::ERR_MASK_ROLE;
                else if (op_next >= wsd_pkg::OPC_FIRST_CTRL && !fin_next)
                    hr_err = wsd_pkg::ERR_CTRL_FRAG;
                else if (op_next >= wsd_pkg::OPC_FIRST_CTRL && acc_next > wsd_pkg::CTRL_MAX_LEN)
                    hr_err = wsd_pkg::ERR_CTRL_LONG;
                else if (op_next == wsd_pkg::OPC_CONT && !frag_cur)
                    hr_err = wsd_pkg::ERR_UNEXP_CONT;
                else if (op_next != wsd_pkg::OPC_CONT && op_next < wsd_pkg::OPC_FIRST_CTRL
                         && frag_cur)
                    hr_err = wsd_pkg::ERR_EXP_CONT;
                else
                    hr_err = wsd_pkg::ERR_NONE;

                if (hr_err != wsd_pkg::ERR_NONE)
                begin
                    err = hr_err;
                end
                else
                begin
                    ev        = wsd_pkg::EV_HDR_DONE;
                    rem_next  = acc_next;
                    kidx_next = '0;
                    if (acc_next == 63'd0)
                    begin
                        do_end = 1'b1;
                        ends   = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_PAYLOAD;
                    end
                end
            end

            // Close the frame and track fragmentation of data frames
            if (do_end)
            begin
                if (op_next < wsd_pkg::OPC_FIRST_CTRL)
                    frag_next = !fin_next;
                phase_next = wsd_pkg::PH_HDR0;
                lrd_next   = '0;
                mrd_next   = '0;
                rem_next   = '0;
                kidx_next  = '0;
            end

            // Latch the first error
            if (err != wsd_pkg::ERR_NONE)
            begin
                err_next = err;
                ev       = wsd_pkg::EV_ERROR;
                ends     = 1'b0;
            end
        end
    end

    // Assemble the result item
    always_comb
    begin
        res                = '0;
        res.data_byte      = data;
        res.opcode         = op_next;
        res.final_fragment = fin_next;
        res.frame_masked   = msk_next;
        res.payload_length = acc_next;
        res.error_code     = (ev == wsd_pkg::EV_ERROR) ? err_next : wsd_pkg::ERR_NONE;
    end

    // Hold the role register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            role_reg <= 1'b1;
        else if (cfg_wr_en)
            role_reg <= cfg_wr_data;
    end

    // Capture input items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wsd_pkg::PH_HDR0;
            fhb_reg   <= '0;
            op_reg    <= '0;
            fin_reg   <= 1'b0;
            msk_reg   <= 1'b0;
            len64_reg <= 1'b0;
            lrd_reg   <= '0;
            acc_reg   <= '0;
            key_reg   <= '0;
            mrd_reg   <= '0;
            rem_reg   <= '0;
            kidx_reg  <= '0;
            frag_reg  <= 1'b0;
            err_reg   <= wsd_pkg::ERR_NONE;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            fhb_reg   <= fhb_next;
            op_reg    <= op_next;
            fin_reg   <= fin_next;
            msk_reg   <= msk_next;
            len64_reg <= len64_next;
            lrd_reg   <= lrd_next;
            acc_reg   <= acc_next;
            key_reg   <= key_next;
            mrd_reg   <= mrd_next;
            rem_reg   <= rem_next;
            kidx_reg  <= kidx_next;
            frag_reg  <= frag_next;
            err_reg   <= err_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res;
            out_user_reg <= ev;
            out_last_reg <= ends;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Error results carry a nonzero code, others carry none
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == wsd_pkg::EV_ERROR) |->
        (m_axis_tdata[80:77] != wsd_pkg::ERR_NONE))
        else $error("error result without error code");

    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != wsd_pkg::EV_ERROR) |->
        (m_axis_tdata[80:77] == wsd_pkg::ERR_NONE))
        else $error("error code on non-error result");

    // Frame end only on header complete or payload
    a_last_ev: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (m_axis_tuser == wsd_pkg::EV_HDR_DONE || m_axis_tuser == wsd_pkg::EV_PAYLOAD))
        else $error("frame end on wrong event");

    // A latched error stays until a start_over item is parsed
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != wsd_pkg::ERR_NONE && !(advance && in_start_reg)) |=> $stable(err_reg))
        else $error("latched error changed without start_over");

endmodule

[test/tb_websocket_frame_deframer.sv]
// Testbench for websocket_frame_deframer: drives received bytes on s_axis and checks each
// m_axis result against an in-bench frame parser, under random idle gaps on both sides.
// Depends on wsd_pkg for phase, event and error codes and for the result layout.
module tb_websocket_frame_deframer;

    // Frame opcodes used to build headers
    localparam logic [3:0] OPC_TEXT     = 4'd1;
    localparam logic [3:0] OPC_BINARY   = 4'd2;
    localparam logic [3:0] OPC_CLOSE    = 4'd8;
    localparam logic [3:0] OPC_PING     = 4'd9;
    localparam logic [3:0] OPC_PONG     = 4'd10;
    localparam logic [3:0] OPC_RESERVED = 4'd11;

    // Length encodings in the second header byte
    localparam int LEN_FORM_7  = 0;
    localparam int LEN_FORM_16 = 1;
    localparam int LEN_FORM_64 = 2;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [1:0]       event_code;
        logic             last;
        wsd_pkg::result_t fields;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Parser state mirrored by the bench
    logic [2:0]  p_stage;
    logic [7:0]  p_hdr0;
    logic [3:0]  p_opc;
    logic        p_fin;
    logic        p_masked;
    logic [3:0]  p_ext_need;
    logic [3:0]  p_ext_got;
    logic [63:0] p_len;
    logic [7:0]  p_key [4];
    logic [2:0]  p_key_got;
    logic [62:0] p_left;
    logic [1:0]  p_key_pos;
    logic        p_frag_open;
    logic [3:0]  p_err;
    logic        p_role = 1'b1;

    frame_result_t deframed_q [$];
    int  fail_count = 0;
    int  taken_items = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    int  taken_results = 0;
    int  seen_results = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;

    websocket_frame_deframer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Clear parser, fragment tracking and the latched error; the role register stays
    function automatic void p_clear();
        p_stage = wsd_pkg::PH_HDR0;
        p_hdr0 = 8'd0;
        p_opc = 4'd0;
        p_fin = 1'b0;
        p_masked = 1'b0;
        p_ext_need = 4'd0;
        p_ext_got = 4'd0;
        p_len = 64'd0;
        for (int i = 0; i < 4; i++)
            p_key[i] = 8'd0;
        p_key_got = 3'd0;
        p_left = 63'd0;
        p_key_pos = 2'd0;
        p_frag_open = 1'b0;
        p_err = wsd_pkg::ERR_NONE;
    endfunction

    // Close the current frame; control frames leave fragment tracking alone
    function automatic void p_end_frame();
        if (p_opc < wsd_pkg::OPC_FIRST_CTRL)
            p_frag_open = !p_fin;
        p_stage = wsd_pkg::PH_HDR0;
        p_ext_need = 4'd0;
        p_ext_got = 4'd0;
        p_key_got = 3'd0;
        p_left = 63'd0;
        p_key_pos = 2'd0;
    endfunction

    // Validate a completed header and enter the payload
    function automatic void p_header_done(output logic [3:0] err, output bit ends);
        err = wsd_pkg::ERR_NONE;
        ends = 1'b0;
        if (p_masked != p_role)
            err = wsd_pkg::ERR_MASK_ROLE;
        else if (p_opc >= wsd_pkg::OPC_FIRST_CTRL)
        begin
            if (!p_fin)
                err = wsd_pkg::ERR_CTRL_FRAG;
            else if (p_len > {1'b0, wsd_pkg::CTRL_MAX_LEN})
                err = wsd_pkg::ERR_CTRL_LONG;
        end
        else if (p_opc == wsd_pkg::OPC_CONT)
        begin
            if (!p_frag_open)
                err = wsd_pkg::ERR_UNEXP_CONT;
        end
        else if (p_frag_open)
            err = wsd_pkg::ERR_EXP_CONT;
        if (err != wsd_pkg::ERR_NONE)
            return;
        p_left = p_len[62:0];
        p_key_pos = 2'd0;
        if (p_left == 63'd0)
        begin
            p_end_frame();
            ends = 1'b1;
        end
        else
            p_stage = wsd_pkg::PH_PAYLOAD;
    endfunction

    // Advance the bench parser by one byte and queue the result it produces
    function automatic void deframe_byte(input logic [7:0] b, input bit restart);
        frame_result_t res;
        logic [3:0]    err;
        bit            ends;
        bit            hdr_done;
        logic [7:0]    data;
        logic [6:0]    lf;
        res.event_code = wsd_pkg::EV_HDR_BYTE;
        err = wsd_pkg::ERR_NONE;
        ends = 1'b0;
        hdr_done = 1'b0;
        data = 8'd0;
        lf = b[6:0];
        if (restart)
            p_clear();
        if (p_err != wsd_pkg::ERR_NONE)
            res.event_code = wsd_pkg::EV_ERROR;
        else
        begin
            unique case (p_stage)
                wsd_pkg::PH_HDR0:
                begin
                    p_hdr0 = b;
                    p_stage = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1:
                begin
                    if (p_hdr0[6:4] != 3'd0)
                        err = wsd_pkg::ERR_RSV;
                    else
                    begin
                        p_fin = p_hdr0[7];
                        p_opc = p_hdr0[3:0];
                        p_masked = 1'b0;
                        p_len = 64'd0;
                        if (!((p_opc <= OPC_BINARY)
                              || (p_opc >= OPC_CLOSE && p_opc <= OPC_PONG)))
                            err = wsd_pkg::ERR_OPCODE;
                        else
                        begin
                            p_masked = b[7];
                            p_ext_got = 4'd0;
                            p_key_got = 3'd0;
                            if (lf < wsd_pkg::LEN_EXT16)
                            begin
                                p_len = {57'd0, lf};
                                if (p_masked)
                                    p_stage = wsd_pkg::PH_MASK;
                                else
                                begin
                                    p_header_done(err, ends);
                                    hdr_done = 1'b1;
                                end
                            end
                            else
                            begin
                                p_ext_need = (lf == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
                                p_stage = wsd_pkg::PH_EXTLEN;
                            end
                        end
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    if (p_ext_need == 4'd8 && p_ext_got == 4'd0 && b[7])
                        err = wsd_pkg::ERR_LEN_MSB;
                    else
                    begin
                        p_len = {p_len[55:0], b};
                        p_ext_got = p_ext_got + 4'd1;
                        if (p_ext_got == p_ext_need)
                        begin
                            if (p_masked)
                                p_stage = wsd_pkg::PH_MASK;
                            else
                            begin
                                p_header_done(err, ends);
                                hdr_done = 1'b1;
                            end
                        end
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    p_key[p_key_got[1:0]] = b;
                    p_key_got = p_key_got + 3'd1;
                    if (p_key_got >= 3'd4)
                    begin
                        p_header_done(err, ends);
                        hdr_done = 1'b1;
                    end
                end
                default:
                begin
                    res.event_code = wsd_pkg::EV_PAYLOAD;
                    data = p_masked ? (b ^ p_key[p_key_pos]) : b;
                    p_key_pos = p_key_pos + 2'd1;
                    p_left = p_left - 63'd1;
                    if (p_left == 63'd0)
                    begin
                        p_end_frame();
                        ends = 1'b1;
                    end
                end
            endcase
            if (err != wsd_pkg::ERR_NONE)
            begin
                p_err = err;
                res.event_code = wsd_pkg::EV_ERROR;
                ends = 1'b0;
            end
            else if (hdr_done)
                res.event_code = wsd_pkg::EV_HDR_DONE;
        end
        res.last = ends;
        res.fields.pad = 7'd0;
        res.fields.error_code = (res.event_code == wsd_pkg::EV_ERROR) ? p_err
                                                                       : wsd_pkg::ERR_NONE;
        res.fields.payload_length = p_len[62:0];
        res.fields.frame_masked = p_masked;
        res.fields.final_fragment = p_fin;
        res.fields.opcode = p_opc;
        res.fields.data_byte = data;
        deframed_q.push_back(res);
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endtask

    // Hold the result channel ready after a random stall per item
    always @(negedge clk)
    begin
        if (seen_results != taken_results)
        begin
            seen_results = taken_results;
            stall_left = recv_idle_on ? int'($urandom_range(0, 16)) : 0;
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each taken result with the oldest predicted one
    always @(posedge clk)
    begin
        frame_result_t    want;
        wsd_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = wsd_pkg::result_t'(m_axis_tdata);
            taken_results++;
            if (deframed_q.size() == 0)
                log_failure($sformatf("unexpected result ev=%0d data=%h",
                                      m_axis_tuser, m_axis_tdata));
            else
            begin
                want = deframed_q.pop_front();
                if (m_axis_tuser !== want.event_code || m_axis_tlast !== want.last
                    || got.data_byte !== want.fields.data_byte
                    || got.opcode !== want.fields.opcode
                    || got.final_fragment !== want.fields.final_fragment
                    || got.frame_masked !== want.fields.frame_masked
                    || got.payload_length !== want.fields.payload_length
                    || got.error_code !== want.fields.error_code
                    || got.pad !== want.fields.pad)
                    log_failure({
                        $sformatf("exp ev=%0d end=%0d byte=%h opc=%0d fin=%0d msk=%0d",
                                  want.event_code, want.last, want.fields.data_byte,
                                  want.fields.opcode, want.fields.final_fragment,
                                  want.fields.frame_masked),
                        $sformatf(" len=%h err=%0d pad=%h",
                                  want.fields.payload_length, want.fields.error_code,
                                  want.fields.pad),
                        $sformatf(" | got ev=%0d end=%0d byte=%h opc=%0d fin=%0d msk=%0d",
                                  m_axis_tuser, m_axis_tlast, got.data_byte, got.opcode,
                                  got.final_fragment, got.frame_masked),
                        $sformatf(" len=%h err=%0d pad=%h",
                                  got.payload_length, got.error_code, got.pad)});
            end
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input bit restart);
        int gap;
        gap = send_idle_on ? int'($urandom_range(0, 16)) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (restart || p_err == wsd_pkg::ERR_NONE)
            taken_items++;
        deframe_byte(b, restart);
    endtask

    function automatic logic [7:0] frame_hdr0(input bit fin, input logic [2:0] rsv,
                                              input logic [3:0] opc);
        frame_hdr0 = {fin, rsv, opc};
    endfunction

    // Send a frame header, optional extended length and key, then npay payload bytes
    task automatic send_frame(input bit restart, input bit fin, input logic [2:0] rsv,
                              input logic [3:0] opc, input bit masked, input logic [63:0] len,
                              input int form, input int npay);
        send_byte(frame_hdr0(fin, rsv, opc), restart);
        unique case (form)
            LEN_FORM_7:
                send_byte({masked, len[6:0]}, 1'b0);
            LEN_FORM_16:
            begin
                send_byte({masked, wsd_pkg::LEN_EXT16}, 1'b0);
                send_byte(len[15:8], 1'b0);
                send_byte(len[7:0], 1'b0);
            end
            default:
            begin
                send_byte({masked, wsd_pkg::LEN_EXT64}, 1'b0);
                for (int i = 7; i >= 0; i--)
                    send_byte(len[i*8 +: 8], 1'b0);
            end
        endcase
        if (masked)
            repeat (4)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (npay)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_role(input bit server);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= server;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        p_role = server;
    endtask

    // Reset role is server: an unmasked frame fails, a masked one unmasks
    task automatic test_reset_role();
        send_frame(1'b0, 1'b1, 3'd0, OPC_TEXT, 1'b0, 64'd0, LEN_FORM_7, 0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_frame(1'b1, 1'b1, 3'd0, OPC_TEXT, 1'b1, 64'd3, LEN_FORM_7, 3);
    endtask

    // Reserved-bit, opcode, control-frame, continuation and length-MSB checks; the first error repeats on the next byte
    task automatic test_header_errors();
        set_role(1'b0);
        send_frame(1'b1, 1'b1, 3'b100, OPC_TEXT, 1'b0, 64'd0, LEN_FORM_7, 1);
        send_frame(1'b1, 1'b1, 3'd0, OPC_RESERVED, 1'b0, 64'd0, LEN_FORM_7, 0);
        send_frame(1'b1, 1'b0, 3'd0, OPC_PING, 1'b0, 64'd0, LEN_FORM_7, 0);
        send_frame(1'b1, 1'b1, 3'd0, OPC_CLOSE, 1'b0, 64'd126, LEN_FORM_16, 0);
        send_frame(1'b1, 1'b1, 3'd0, wsd_pkg::OPC_CONT, 1'b0, 64'd0, LEN_FORM_7, 0);
        send_byte(frame_hdr0(1'b1, 3'd0, OPC_BINARY), 1'b1);
        send_byte({1'b0, wsd_pkg::LEN_EXT64}, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Fragmented message with a ping in between, then a data frame while one is open
    task automatic test_fragments();
        send_frame(1'b1, 1'b0, 3'd0, OPC_TEXT, 1'b0, 64'd1, LEN_FORM_7, 1);
        send_frame(1'b0, 1'b1, 3'd0, OPC_PING, 1'b0, 64'd0, LEN_FORM_7, 0);
        send_frame(1'b0, 1'b0, 3'd0, wsd_pkg::OPC_CONT, 1'b0, 64'd0, LEN_FORM_7, 0);
        send_frame(1'b0, 1'b1, 3'd0, OPC_BINARY, 1'b0, 64'd0, LEN_FORM_7, 0);
    endtask

    // Largest 16- and 64-bit declared lengths, cut short by a restart
    task automatic test_long_lengths();
        send_frame(1'b1, 1'b1, 3'd0, OPC_BINARY, 1'b0, 64'hFFFF, LEN_FORM_16, 1);
        send_frame(1'b1, 1'b1, 3'd0, OPC_BINARY, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF,
                   LEN_FORM_64, 1);
    endtask

    // Role change between header bytes applies when the header completes
    task automatic test_role_midframe();
        send_byte(frame_hdr0(1'b1, 3'd0, OPC_TEXT), 1'b1);
        send_byte({1'b1, 7'd1}, 1'b0);
        set_role(1'b1);
        repeat (5)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Mostly well-formed frame sequences, some broken headers and raw noise
    task automatic test_random_traffic(input bit server, input int count);
        int          start;
        int          sel;
        int          form;
        int          npay;
        bit          restart;
        bit          frag;
        bit          fin;
        bit          masked;
        logic [2:0]  rsv;
        logic [3:0]  opc;
        logic [63:0] len;
        set_role(server);
        start = taken_items;
        while (taken_items - start < count)
        begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            restart = (p_stage != wsd_pkg::PH_HDR0) || (p_err != wsd_pkg::ERR_NONE)
                      || ($urandom_range(0, 19) == 0);
            frag = restart ? 1'b0 : p_frag_open;
            sel = int'($urandom_range(0, 99));
            form = int'($urandom_range(0, 9));
            form = (form < 8) ? LEN_FORM_7 : (form == 8) ? LEN_FORM_16 : LEN_FORM_64;
            if (sel < 75)
            begin
                fin = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                begin
                    opc = ($urandom_range(0, 2) == 0) ? OPC_CLOSE
                        : ($urandom_range(0, 1) == 0) ? OPC_PING : OPC_PONG;
                    fin = 1'b1;
                    len = 64'($urandom_range(0, 8));
                end
                else
                begin
                    opc = frag ? wsd_pkg::OPC_CONT
                        : ($urandom_range(0, 1) == 0) ? OPC_TEXT : OPC_BINARY;
                    len = (form == LEN_FORM_16) ? 64'($urandom_range(0, 300))
                                                : 64'($urandom_range(0, 10));
                end
                send_frame(restart, fin, 3'd0, opc, p_role, len, form, int'(len));
            end
            else if (sel < 90)
            begin
                fin = 1'($urandom_range(0, 1));
                rsv = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
                opc = 4'($urandom_range(0, 15));
                masked = ($urandom_range(0, 3) == 0) ? !p_role : p_role;
                len = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(0, 140));
                npay = (len < 64'd13) ? int'($urandom_range(0, int'(len)))
                                      : int'($urandom_range(0, 12));
                send_frame(restart, fin, rsv, opc, masked, len,
                           int'($urandom_range(0, 2)), npay);
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 5))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial
    begin
        p_clear();
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        test_reset_role();
        test_header_errors();
        test_fragments();
        test_long_lengths();
        test_role_midframe();
        test_random_traffic(1'b0, 370);
        test_random_traffic(1'b1, 370);
        test_random_traffic(1'b0, 370);
        test_random_traffic(1'b1, 370);
        settle();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && deframed_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
